/* rtl/sprite_xor_framebuffer_macros.svh */
// Assertion macros for the sprite XOR framebuffer
`ifndef SPRITE_XOR_FRAMEBUFFER_MACROS_SVH
`define SPRITE_XOR_FRAMEBUFFER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define SFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/sfb_pkg.sv */
// Shared types and constants for the sprite XOR framebuffer
package sfb_pkg;

  localparam int PLANES  = 2;
  localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int WORD_W  = 64;
  localparam int ADDR_W  = PLANE_W + 7;
  localparam int DEPTH   = PLANES * 128;

  localparam logic [2:0] REG_HIGH_RES   = 3'd0;
  localparam logic [2:0] REG_PLANE_MASK = 3'd1;
  localparam logic [2:0] REG_CLIP       = 3'd2;
  localparam logic [2:0] REG_CNT_EXCEED = 3'd3;
  localparam logic [2:0] REG_CNT_HITS   = 3'd4;

  typedef enum logic [2:0] {
    MODE_DRAW     = 3'd0,
    MODE_SCR_DOWN = 3'd1,
    MODE_SCR_UP   = 3'd2,
    MODE_SCR_LEFT = 3'd3,
    MODE_SCR_RGHT = 3'd4,
    MODE_CLEAR    = 3'd5,
    MODE_READ     = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRW_RD,
    ST_DRW_MOD,
    ST_DRW_FIN,
    ST_PIX_RD,
    ST_PIX_OUT,
    ST_WALK,
    ST_CLR,
    ST_V_RD,
    ST_V_WR,
    ST_H_RD0,
    ST_H_RD1,
    ST_H_WR0,
    ST_H_WR1
  } state_e;

  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic              any_col;
  } draw_mask_t;

endpackage

/* rtl/sfb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read
module sfb_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/sfb_draw_mask.sv */
// Sprite row to word mask: wrap or clip columns and select one 64-bit word
module sfb_draw_mask (
  input  logic [7:0]          pos_x_i,
  input  logic                wide_i,
  input  logic [15:0]         bits_i,
  input  logic                high_res_i,
  input  logic                clip_i,
  input  logic                word_i,
  output sfb_pkg::draw_mask_t dm_o
);

  always_comb begin
    logic [8:0] cx;
    logic [6:0] x7;
    logic       in_scr;
    logic       ok;
    dm_o = '0;
    for (int c = 0; c < 16; c++) begin
      cx     = {1'b0, pos_x_i} + 9'(c);
      in_scr = high_res_i ? (cx < 9'd128) : (cx < 9'd64);
      ok     = (wide_i || (c < 8)) && !(clip_i && !in_scr);
      x7     = high_res_i ? cx[6:0] : {1'b0, cx[5:0]};
      if (ok) begin
        dm_o.any_col = 1'b1;
      end
      if (ok && bits_i[15-c] && (x7[6] == word_i)) begin
        dm_o.mask[6'd63 - x7[5:0]] = 1'b1;
      end
    end
  end

endmodule

/* rtl/sprite_xor_framebuffer.sv */
// Top level: multi-plane one-bit framebuffer with sprite XOR, scroll, clear and pixel read
//
// A command is taken when start_i is high and busy_o is low; a result (end of a draw
// marked last_row_i, or a pixel read) appears for one cycle on done_o and cannot be
// stalled. All pixel state lives in one 64-bit-wide RAM with a registered read, addressed
// by plane, row and word, so timing follows its single read and write port: a draw row
// does one read-modify-write per word, a pixel read does one read, and mode 7 does nothing.
// Clear writes each word once, a vertical scroll reads and writes each word, a horizontal
// scroll reads both words of a row and writes back the words in use, over each selected
// plane (32 or 64 rows of 1 or 2 words), after a check of each plane. Reset clears every pixel at once.
module sprite_xor_framebuffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic        plane_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [3:0]  row_index_i,
  input  logic        wide_sprite_i,
  input  logic [15:0] sprite_bits_i,
  input  logic [3:0]  scroll_count_i,
  input  logic        last_row_i,
  output logic        done_o,
  output logic [5:0]  collision_o,
  output logic        pixel_value_o,
  output logic        is_pixel_read_o
);

  localparam int AW = sfb_pkg::ADDR_W;
  localparam int PW = sfb_pkg::PLANE_W;

  sfb_pkg::state_e state_q, state_d;

  logic                high_res_q, clip_q, cnt_exc_q, cnt_hits_q;
  logic [1:0]          pmask_q;
  sfb_pkg::mode_e      mode_q;
  logic                req_plane_q;
  logic [7:0]          px_q, py_q;
  logic [8:0]          y_q;
  logic                wide_q, last_q;
  logic [15:0]         bits_q;
  logic [3:0]          cnt_q;
  logic [PW-1:0]       plane_q, plane_d;
  logic [5:0]          row_q, row_d;
  logic                word_q, word_d;
  logic                hit_q, hit_d;
  logic [5:0]          total_q, total_d;
  logic [63:0]         w0_q, w0_d, w1_q, w1_d;
  logic                done_q, done_d;
  logic [5:0]          coll_q, coll_d;
  logic                pix_q, pix_d, isrd_q, isrd_d;

  logic [sfb_pkg::DEPTH-1:0] valid_q;
  logic                      vrd_q;
  logic                      ram_we;
  logic [AW-1:0]             waddr, raddr;
  logic [63:0]               wdata, ram_rdata, rd;
  sfb_pkg::draw_mask_t       dm;

  logic       accept;
  logic [5:0] hlast;
  logic [6:0] scr_h;
  logic       last_word, row_end, plane_last, sel;
  logic [5:0] dy, sy;
  logic [6:0] up_sum;
  logic       has_src;
  logic       y_on;
  logic [5:0] tot_inc;

  assign cfg_ready_o     = 1'b1;
  assign busy_o          = (state_q != sfb_pkg::ST_IDLE);
  assign accept          = start_i && !busy_o;
  assign done_o          = done_q;
  assign collision_o     = coll_q;
  assign pixel_value_o   = pix_q;
  assign is_pixel_read_o = isrd_q;

  assign rd = vrd_q ? ram_rdata : '0;

  sfb_ram #(.Width(sfb_pkg::WORD_W), .Depth(sfb_pkg::DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  sfb_draw_mask u_mask (
    .pos_x_i    (px_q),
    .wide_i     (wide_q),
    .bits_i     (bits_q),
    .high_res_i (high_res_q),
    .clip_i     (clip_q),
    .word_i     (word_q),
    .dm_o       (dm)
  );

  // screen geometry and walk position
  always_comb begin
    hlast      = high_res_q ? 6'd63 : 6'd31;
    scr_h      = high_res_q ? 7'd64 : 7'd32;
    last_word  = !high_res_q || word_q;
    row_end    = (row_q == hlast);
    plane_last = (plane_q == PW'(sfb_pkg::PLANES - 1));
    sel        = ((32'(plane_q) < sfb_pkg::PLANES)) && pmask_q[plane_q];
    y_on       = (y_q < {2'b00, scr_h});
    up_sum     = {1'b0, row_q} + {3'b000, cnt_q};
    if (mode_q == sfb_pkg::MODE_SCR_DOWN) begin
      dy      = hlast - row_q;
      has_src = (dy >= {2'b00, cnt_q});
      sy      = dy - {2'b00, cnt_q};
    end else begin
      dy      = row_q;
      has_src = (up_sum < scr_h);
      sy      = up_sum[5:0];
    end
    tot_inc = (hit_q && total_q != 6'd63) ? total_q + 6'd1 : total_q;
  end

  always_comb begin
    state_d = state_q;
    plane_d = plane_q;
    row_d   = row_q;
    word_d  = word_q;
    hit_d   = hit_q;
    total_d = total_q;
    w0_d    = w0_q;
    w1_d    = w1_q;
    done_d  = 1'b0;
    coll_d  = coll_q;
    pix_d   = pix_q;
    isrd_d  = isrd_q;
    ram_we  = 1'b0;
    waddr   = {plane_q, row_q, word_q};
    wdata   = '0;
    raddr   = {plane_q, row_q, word_q};

    case (state_q)
      sfb_pkg::ST_IDLE: begin
        if (accept) begin
          plane_d = '0;
          row_d   = '0;
          word_d  = 1'b0;
          hit_d   = 1'b0;
          case (sfb_pkg::mode_e'(mode_i))
            sfb_pkg::MODE_DRAW: begin
              plane_d = PW'(plane_i);
              state_d = sfb_pkg::ST_DRW_RD;
            end
            sfb_pkg::MODE_READ: begin
              plane_d = PW'(plane_i);
              state_d = sfb_pkg::ST_PIX_RD;
            end
            sfb_pkg::MODE_SCR_DOWN, sfb_pkg::MODE_SCR_UP, sfb_pkg::MODE_SCR_LEFT,
            sfb_pkg::MODE_SCR_RGHT, sfb_pkg::MODE_CLEAR: begin
              state_d = sfb_pkg::ST_WALK;
            end
            default: state_d = sfb_pkg::ST_IDLE;
          endcase
        end
      end

      sfb_pkg::ST_DRW_RD: begin
        raddr   = {plane_q, y_q[5:0], word_q};
        state_d = sfb_pkg::ST_DRW_MOD;
      end

      sfb_pkg::ST_DRW_MOD: begin
        waddr = {plane_q, y_q[5:0], word_q};
        wdata = rd ^ dm.mask;
        if (sel && y_on) begin
          ram_we = 1'b1;
          if ((rd & dm.mask) != '0) hit_d = 1'b1;
        end else if (sel && cnt_exc_q && dm.any_col) begin
          hit_d = 1'b1;
        end
        if (last_word) begin
          state_d = sfb_pkg::ST_DRW_FIN;
        end else begin
          word_d  = 1'b1;
          state_d = sfb_pkg::ST_DRW_RD;
        end
      end

      sfb_pkg::ST_DRW_FIN: begin
        total_d = tot_inc;
        if (last_q) begin
          done_d  = 1'b1;
          coll_d  = cnt_hits_q ? tot_inc : {5'b0, (tot_inc != 6'd0)};
          pix_d   = 1'b0;
          isrd_d  = 1'b0;
          total_d = '0;
        end
        state_d = sfb_pkg::ST_IDLE;
      end

      sfb_pkg::ST_PIX_RD: begin
        raddr   = {plane_q, py_q[5:0], px_q[6]};
        state_d = sfb_pkg::ST_PIX_OUT;
      end

      sfb_pkg::ST_PIX_OUT: begin
        done_d = 1'b1;
        coll_d = '0;
        isrd_d = 1'b1;
        pix_d  = (32'(req_plane_q) < sfb_pkg::PLANES)
                 && (px_q < (high_res_q ? 8'd128 : 8'd64))
                 && (py_q < {1'b0, scr_h}) && rd[6'd63 - px_q[5:0]];
        state_d = sfb_pkg::ST_IDLE;
      end

      sfb_pkg::ST_WALK: begin
        row_d  = '0;
        word_d = 1'b0;
        if (sel) begin
          case (mode_q)
            sfb_pkg::MODE_CLEAR:    state_d = sfb_pkg::ST_CLR;
            sfb_pkg::MODE_SCR_LEFT,
            sfb_pkg::MODE_SCR_RGHT: state_d = sfb_pkg::ST_H_RD0;
            default:                state_d = sfb_pkg::ST_V_RD;
          endcase
        end else if (plane_last) begin
          state_d = sfb_pkg::ST_IDLE;
        end else begin
          plane_d = plane_q + PW'(1);
        end
      end

      sfb_pkg::ST_CLR, sfb_pkg::ST_V_WR: begin
        ram_we = 1'b1;
        if (state_q == sfb_pkg::ST_CLR) begin
          waddr = {plane_q, row_q, word_q};
          wdata = '0;
        end else begin
          waddr = {plane_q, dy, word_q};
          wdata = has_src ? rd : '0;
        end
        // advance word, then row, then plane
        if (state_q == sfb_pkg::ST_V_WR) state_d = sfb_pkg::ST_V_RD;
        if (!last_word) begin
          word_d = 1'b1;
        end else begin
          word_d = 1'b0;
          if (!row_end) begin
            row_d = row_q + 6'd1;
          end else if (plane_last) begin
            state_d = sfb_pkg::ST_IDLE;
          end else begin
            plane_d = plane_q + PW'(1);
            state_d = sfb_pkg::ST_WALK;
          end
        end
      end

      sfb_pkg::ST_V_RD: begin
        raddr   = {plane_q, sy, word_q};
        state_d = sfb_pkg::ST_V_WR;
      end

      sfb_pkg::ST_H_RD0: begin
        raddr   = {plane_q, row_q, 1'b0};
        state_d = sfb_pkg::ST_H_RD1;
      end

      sfb_pkg::ST_H_RD1: begin
        w0_d    = rd;
        raddr   = {plane_q, row_q, 1'b1};
        state_d = sfb_pkg::ST_H_WR0;
      end

      sfb_pkg::ST_H_WR0: begin
        w1_d   = high_res_q ? rd : '0;
        ram_we = 1'b1;
        waddr  = {plane_q, row_q, 1'b0};
        if (mode_q == sfb_pkg::MODE_SCR_LEFT) begin
          wdata = {w0_q[59:0], (high_res_q ? rd[63:60] : 4'b0)};
        end else begin
          wdata = {4'b0, w0_q[63:4]};
        end
        if (high_res_q) begin
          state_d = sfb_pkg::ST_H_WR1;
        end else if (!row_end) begin
          row_d   = row_q + 6'd1;
          state_d = sfb_pkg::ST_H_RD0;
        end else if (plane_last) begin
          state_d = sfb_pkg::ST_IDLE;
        end else begin
          plane_d = plane_q + PW'(1);
          state_d = sfb_pkg::ST_WALK;
        end
      end

      sfb_pkg::ST_H_WR1: begin
        ram_we = 1'b1;
        waddr  = {plane_q, row_q, 1'b1};
        if (mode_q == sfb_pkg::MODE_SCR_LEFT) begin
          wdata = {w1_q[59:0], 4'b0};
        end else begin
          wdata = {w0_q[3:0], w1_q[63:4]};
        end
        if (!row_end) begin
          row_d   = row_q + 6'd1;
          state_d = sfb_pkg::ST_H_RD0;
        end else if (plane_last) begin
          state_d = sfb_pkg::ST_IDLE;
        end else begin
          plane_d = plane_q + PW'(1);
          state_d = sfb_pkg::ST_WALK;
        end
      end

      default: state_d = sfb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sfb_pkg::ST_IDLE;
      high_res_q <= 1'b0;
      pmask_q    <= 2'd1;
      clip_q     <= 1'b0;
      cnt_exc_q  <= 1'b0;
      cnt_hits_q <= 1'b0;
      plane_q    <= '0;
      row_q      <= '0;
      word_q     <= 1'b0;
      hit_q      <= 1'b0;
      total_q    <= '0;
      done_q     <= 1'b0;
      valid_q    <= '0;
      vrd_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      row_q   <= row_d;
      word_q  <= word_d;
      hit_q   <= hit_d;
      total_q <= total_d;
      done_q  <= done_d;
      vrd_q   <= valid_q[raddr];
      if (ram_we) valid_q[waddr] <= 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sfb_pkg::REG_HIGH_RES:   high_res_q <= cfg_data_i[0];
          sfb_pkg::REG_PLANE_MASK: pmask_q    <= cfg_data_i[1:0];
          sfb_pkg::REG_CLIP:       clip_q     <= cfg_data_i[0];
          sfb_pkg::REG_CNT_EXCEED: cnt_exc_q  <= cfg_data_i[0];
          sfb_pkg::REG_CNT_HITS:   cnt_hits_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // request and data holding registers
  always_ff @(posedge clk_i) begin
    w0_q   <= w0_d;
    w1_q   <= w1_d;
    coll_q <= coll_d;
    pix_q  <= pix_d;
    isrd_q <= isrd_d;
    if (accept) begin
      mode_q      <= sfb_pkg::mode_e'(mode_i);
      req_plane_q <= plane_i;
      px_q        <= pos_x_i;
      py_q        <= pos_y_i;
      y_q         <= {1'b0, pos_y_i} + {5'b0, row_index_i};
      wide_q      <= wide_sprite_i;
      bits_q      <= sprite_bits_i;
      cnt_q       <= scroll_count_i;
      last_q      <= last_row_i;
    end
  end

`include "sprite_xor_framebuffer_macros.svh"

  `SFB_ASSERT_NOW(a_no_write_idle, ram_we, state_q != sfb_pkg::ST_IDLE)
  `SFB_ASSERT_NEXT(a_done_src, (state_q == sfb_pkg::ST_PIX_OUT) || ((state_q == sfb_pkg::ST_DRW_FIN) && last_q), done_q)
  `SFB_ASSERT_NOW(a_total_cleared, done_q && !isrd_q, total_q == 6'd0)

endmodule
